FILE: rtl/mlfo_pkg.sv
// ----------------------------------------------------------------------------
// mlfo_pkg
// Shared constants, register and request codes, and the sine table builder
// for the multiphase LFO bank.
// ----------------------------------------------------------------------------
package mlfo_pkg;

   localparam int LFO_MAX_DEF   = 32;
   localparam int SINE_SIZE_DEF = 512;

   // configuration register indexes
   localparam logic [2:0] CSR_LFO_COUNT   = 3'd0;
   localparam logic [2:0] CSR_WAVE_SHAPE  = 3'd1;
   localparam logic [2:0] CSR_RATE_SCALE  = 3'd2;
   localparam logic [2:0] CSR_SPREAD_STEP = 3'd3;
   localparam logic [2:0] CSR_USE_TABLE   = 3'd4;

   // wave shapes; anything else is sine
   localparam logic [2:0] SHAPE_SINE    = 3'd0;
   localparam logic [2:0] SHAPE_SQUARE  = 3'd1;
   localparam logic [2:0] SHAPE_FALLING = 3'd2;
   localparam logic [2:0] SHAPE_RISING  = 3'd3;
   localparam logic [2:0] SHAPE_TENT    = 3'd4;

   // request kinds
   localparam logic [1:0] REQ_TICK      = 2'd0;
   localparam logic [1:0] REQ_SET_PHASE = 2'd1;
   localparam logic [1:0] REQ_WR_OFFSET = 2'd2;

   localparam logic [5:0]  RST_LFO_COUNT  = 6'd1;
   localparam logic [31:0] RST_RATE_SCALE = 32'd366503876;

   // quarter-wave polynomial coefficients, Q30
   localparam logic [63:0] Q30_ONE = 64'd1073741824;
   localparam logic [63:0] C1 = 64'd1686629713;
   localparam logic [63:0] C3 = 64'd693598668;
   localparam logic [63:0] C5 = 64'd85569306;
   localparam logic [63:0] C7 = 64'd5026995;
   localparam logic [63:0] C9 = 64'd172272;

   typedef struct packed {
      logic [5:0]  lfo_count;
      logic [2:0]  wave_shape;
      logic [31:0] rate_scale;
      logic [31:0] spread_step;
      logic        use_table;
   } mlfo_cfg_type;

   // sin(pi/2 * t), t and result in Q30
   function automatic logic [63:0] mlfo_quarter_sine(input logic [63:0] t);
      logic [63:0] t2;
      logic [63:0] r;
      t2 = (t * t) >> 30;
      r  = C9;
      r  = C7 - ((t2 * r) >> 30);
      r  = C5 - ((t2 * r) >> 30);
      r  = C3 - ((t2 * r) >> 30);
      r  = C1 - ((t2 * r) >> 30);
      return (t * r) >> 30;
   endfunction

   // 16384 + round(16384 * sin(2 pi x / 2^32))
   function automatic logic [15:0] mlfo_sine_entry(input logic [31:0] x);
      logic [1:0]  quad;
      logic [63:0] f;
      logic [63:0] t;
      logic [63:0] m;
      quad = x[31:30];
      f    = {34'd0, x[29:0]};
      t    = quad[0] ? (Q30_ONE - f) : f;
      m    = (mlfo_quarter_sine(t) + 64'd32768) >> 16;
      if (m > 64'd16384) m = 64'd16384;
      return quad[1] ? 16'(64'd16384 - m) : 16'(64'd16384 + m);
   endfunction

endpackage

FILE: rtl/multiphase_lfo_bank.sv
// ----------------------------------------------------------------------------
// multiphase_lfo_bank
// Bank of LFOs sharing one phase accumulator, each with its own phase
// offset; emits one level per active LFO on every sample tick.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  req     | in  | req_tvalid/tready    | tuser: kind, tdata: freq, phase, entry
//  rsp     | out | rsp_tvalid/tready    | tdata: lfo index, level; tlast: last
//  csr     | in  | csr_we               | csr_index, csr_wdata
//
//  A tick issues n LFOs (n = active LFO count, 1..LFO_MAX), one per cycle from
//  the issue counter and the single offset-store read port while rsp is not
//  stalled. Each level passes the issue counter, the stage registers and the
//  rsp register; the next request is taken once the issue counter is idle and
//  stage 1 is empty. Reset clears the phase and the offset-store valid bits
//  and sets the registers to their reset values at once. A stalled rsp
//  freezes the whole pipeline; no request is taken while a tick is being issued.
// ----------------------------------------------------------------------------
module multiphase_lfo_bank
   import mlfo_pkg::*;
#(
   parameter int LFO_MAX         = LFO_MAX_DEF,
   parameter int SINE_TABLE_SIZE = SINE_SIZE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // req_type
   input  logic [47:0] req_tdata,   // freq[23:0], phase_value[39:24], entry_index[44:40]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // lfo_index[4:0], level[20:5]
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int AW = (LFO_MAX > 1) ? $clog2(LFO_MAX) : 1;
   localparam int CW = $clog2(LFO_MAX + 1);
   localparam int RW = $clog2(SINE_TABLE_SIZE + 1);
   localparam int PW = 32 + RW;

   logic        [1:0]  req_kind;
   logic signed [23:0] req_freq;
   logic        [15:0] req_phase;
   logic        [4:0]  req_entry;

   assign req_kind  = req_tuser;
   assign req_freq  = $signed(req_tdata[23:0]);
   assign req_phase = req_tdata[39:24];
   assign req_entry = req_tdata[44:40];

   mlfo_cfg_type cfg_ff;

   logic [15:0]        ofs_mem [LFO_MAX];
   logic [LFO_MAX-1:0] ofs_vld_ff;
   logic [15:0]        ofs_rd_ff;
   logic               ofs_ok_ff;

   logic [31:0] phase_acc_ff;
   logic [55:0] prod_ff;
   logic [31:0] inc_ff;

   logic          busy_ff;
   logic [CW-1:0] cnt_ff;
   logic [31:0]   spr_ff;
   logic [CW-1:0] n_eff;
   logic          last_issue;

   logic        s1_v_ff, s1_last_ff;
   logic [4:0]  s1_idx_ff;
   logic [31:0] s1_spr_ff;
   logic [31:0] off_in;

   logic        s2_v_ff, s2_last_ff;
   logic [4:0]  s2_idx_ff;
   logic [31:0] p_ff;
   logic [PW-1:0] pos;
   logic [RW-1:0] i0;
   logic [15:0] shp_lvl;
   logic        is_sine;
   logic [32:0] tri_neg;

   logic        s3_v_ff, s3_last_ff, s3_sine_ff;
   logic [4:0]  s3_idx_ff;
   logic [15:0] rom_a_ff, rom_b_ff, s3_lvl_ff;
   logic [31:0] frac_ff;
   logic signed [16:0] diff;
   logic signed [49:0] interp;
   logic signed [49:0] interp_rnd;
   logic signed [17:0] sin_lvl;

   logic        rsp_v_ff, rsp_last_ff;
   logic [4:0]  rsp_idx_ff;
   logic [15:0] rsp_lvl_ff;

   logic adv;
   logic req_fire;

   // sine table, SINE_TABLE_SIZE + 1 entries, built at elaboration
   logic [15:0] sine_rom [SINE_TABLE_SIZE + 1];

   for (genvar k = 0; k <= SINE_TABLE_SIZE; k++) begin : g_rom
      localparam logic [63:0] XK = (64'(k) << 32) / SINE_TABLE_SIZE;
      assign sine_rom[k] = mlfo_sine_entry(XK[31:0]);
   end

   assign adv        = !rsp_v_ff || rsp_tready;
   assign req_tready = !busy_ff && !s1_v_ff;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      if (cfg_ff.lfo_count == 6'd0) begin
         n_eff = CW'(1);
      end else if (32'(cfg_ff.lfo_count) > LFO_MAX) begin
         n_eff = CW'(LFO_MAX);
      end else begin
         n_eff = CW'(cfg_ff.lfo_count);
      end
   end

   assign last_issue = (CW'(cnt_ff + 1'b1) == n_eff);

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lfo_count   <= RST_LFO_COUNT;
         cfg_ff.wave_shape  <= SHAPE_SINE;
         cfg_ff.rate_scale  <= RST_RATE_SCALE;
         cfg_ff.spread_step <= 32'd0;
         cfg_ff.use_table   <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LFO_COUNT:   cfg_ff.lfo_count   <= csr_wdata[5:0];
            CSR_WAVE_SHAPE:  cfg_ff.wave_shape  <= csr_wdata[2:0];
            CSR_RATE_SCALE:  cfg_ff.rate_scale  <= csr_wdata;
            CSR_SPREAD_STEP: cfg_ff.spread_step <= csr_wdata;
            CSR_USE_TABLE:   cfg_ff.use_table   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // offset store: written by requests, read at the issue counter whenever the pipeline advances
   always_ff @(posedge clock) begin
      if (req_fire && req_kind == REQ_WR_OFFSET && 32'(req_entry) < LFO_MAX) begin
         ofs_mem[AW'(req_entry)] <= req_phase;
      end
      if (adv) begin
         ofs_rd_ff <= ofs_mem[AW'(cnt_ff)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ofs_vld_ff <= '0;
         ofs_ok_ff  <= 1'b0;
      end else begin
         if (req_fire && req_kind == REQ_WR_OFFSET && 32'(req_entry) < LFO_MAX) begin
            ofs_vld_ff[AW'(req_entry)] <= 1'b1;
         end
         if (adv) begin
            ofs_ok_ff <= ofs_vld_ff[AW'(cnt_ff)];
         end
      end
   end

   // phase increment: round(freq * rate_scale / 2^24)
   always_ff @(posedge clock) begin
      if (req_fire && req_kind == REQ_TICK) begin
         prod_ff <= 56'(req_freq * $signed({1'b0, cfg_ff.rate_scale}));
      end
      inc_ff <= 32'((prod_ff + 56'd8388608) >> 24);
   end

   // issue counter and phase accumulator
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         cnt_ff       <= '0;
         spr_ff       <= 32'd0;
         phase_acc_ff <= 32'd0;
      end else begin
         if (req_fire && req_kind == REQ_TICK) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            spr_ff  <= 32'd0;
         end else if (busy_ff && adv) begin
            if (last_issue) begin
               busy_ff <= 1'b0;
            end else begin
               cnt_ff <= CW'(cnt_ff + 1'b1);
               spr_ff <= spr_ff + cfg_ff.spread_step;
            end
         end
         if (req_fire && req_kind == REQ_SET_PHASE) begin
            phase_acc_ff <= {req_phase, 16'd0};
         end else if (adv && s1_v_ff && s1_last_ff) begin
            phase_acc_ff <= phase_acc_ff + inc_ff;
         end
      end
   end

   // stage 1: offset and LFO phase
   assign off_in = cfg_ff.use_table ? {(ofs_ok_ff ? ofs_rd_ff : 16'd0), 16'd0} : s1_spr_ff;

   // stage 2: table position and simple shapes
   assign pos     = PW'(p_ff) * PW'(SINE_TABLE_SIZE);
   assign i0      = pos[32 +: RW];
   assign tri_neg = 33'h1_0000_0000 - {1'b0, p_ff};

   always_comb begin
      is_sine = 1'b0;
      case (cfg_ff.wave_shape)
         SHAPE_SQUARE:  shp_lvl = p_ff[31] ? 16'd32768 : 16'd0;
         SHAPE_FALLING: shp_lvl = 16'd32768 - {1'b0, p_ff[31:17]};
         SHAPE_RISING:  shp_lvl = {1'b0, p_ff[31:17]};
         SHAPE_TENT:    shp_lvl = p_ff[31] ? tri_neg[31:16] : {1'b0, p_ff[30:16]};
         default: begin
            shp_lvl = 16'd0;
            is_sine = 1'b1;
         end
      endcase
   end

   // stage 3: linear interpolation, a + floor(((b - a) * frac + 2^31) / 2^32)
   assign diff       = $signed({1'b0, rom_b_ff}) - $signed({1'b0, rom_a_ff});
   assign interp     = 50'(diff * $signed({1'b0, frac_ff}));
   assign interp_rnd = interp + 50'sd2147483648;
   assign sin_lvl    = $signed({2'b00, rom_a_ff}) + $signed(interp_rnd[49:32]);

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_idx_ff  <= 5'(cnt_ff);
         s1_last_ff <= last_issue;
         s1_spr_ff  <= spr_ff;

         s2_idx_ff  <= s1_idx_ff;
         s2_last_ff <= s1_last_ff;
         p_ff       <= phase_acc_ff + off_in;

         s3_idx_ff  <= s2_idx_ff;
         s3_last_ff <= s2_last_ff;
         s3_sine_ff <= is_sine;
         s3_lvl_ff  <= shp_lvl;
         rom_a_ff   <= sine_rom[i0];
         rom_b_ff   <= sine_rom[RW'(i0 + 1'b1)];
         frac_ff    <= pos[31:0];

         rsp_idx_ff  <= s3_idx_ff;
         rsp_last_ff <= s3_last_ff;
         rsp_lvl_ff  <= s3_sine_ff ? 16'(sin_lvl) : s3_lvl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff  <= busy_ff;
         s2_v_ff  <= s1_v_ff;
         s3_v_ff  <= s2_v_ff;
         rsp_v_ff <= s3_v_ff;
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = {3'd0, rsp_lvl_ff, rsp_idx_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multiphase LFO bank. A directed table covers
// every shape, both frequency extremes, count clamping and ignored requests.
// Random phases with shuffled settings follow. Every level the bank emits
// is checked, against a typed level or a local predictor of the shared phase
// accumulator and the per-LFO offsets, under random idling on both streams.
// ----------------------------------------------------------------------------
module tb_top
   import mlfo_pkg::*;
();

   localparam logic [1:0] REQ_UNDEFINED   = 2'd3;
   localparam logic [2:0] SHAPE_UNDEFINED = 3'd7;
   localparam logic [2:0] CSR_SPARE_LO    = 3'd5;
   localparam logic [2:0] CSR_SPARE_HI    = 3'd7;

   localparam logic [23:0] FREQ_MAX = 24'h7F_FFFF;
   localparam logic [23:0] FREQ_MIN = 24'h80_0000;

   localparam int QUIET_CYCLES    = 16;
   localparam int HOLD_CYCLES     = 400;
   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int RANDOM_PHASES   = 8;
   localparam int PRESSURE_PHASE  = 2;
   localparam int ITEMS_PER_PHASE = 55;

   // polynomial for sin(pi/2 * t), Q30
   localparam logic [63:0] K1 = 64'd1686629713;
   localparam logic [63:0] K3 = 64'd693598668;
   localparam logic [63:0] K5 = 64'd85569306;
   localparam logic [63:0] K7 = 64'd5026995;
   localparam logic [63:0] K9 = 64'd172272;

   typedef struct packed {
      logic [4:0]  lfo_index;
      logic [15:0] level;
      logic        last;
   } lfo_level_type;

   typedef struct packed {
      logic        is_csr;
      logic [2:0]  code;    // request kind or register index
      logic [31:0] value;   // frequency or register value
      logic [15:0] phase;
      logic [4:0]  entry;
      logic        pin;     // level typed in below
      logic [15:0] level;
   } plan_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [1:0]  req_tuser = REQ_TICK;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = CSR_LFO_COUNT;
   logic [31:0] csr_wdata = '0;

   // tb-side tag traveling with the request
   logic        pinned = 1'b0;
   logic [15:0] pinned_level = '0;

   // predictor state
   logic [15:0] sine_lut [0:512];
   logic [5:0]  count_cfg;
   logic [2:0]  shape_cfg;
   logic [31:0] rate_cfg;
   logic [31:0] spread_cfg;
   logic        use_table_cfg;
   logic [31:0] phase_now;
   logic [15:0] offset_mem [0:31];

   lfo_level_type expected_levels [$];
   plan_row_type  plan [$];
   int         error_count = 0;
   int         idle_cycles = 0;
   bit         sender_idles = 1'b1;
   bit         steady_run = 1'b0;
   bit         hold_pending = 1'b0;

   multiphase_lfo_bank dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      error_count++;
      $display("%0t ERROR %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   function automatic plan_row_type req_row(input logic [1:0] kind, input logic [23:0] freq,
                                            input logic [15:0] ph, input logic [4:0] entry,
                                            input logic pin, input logic [15:0] lvl);
      plan_row_type r;
      r = '0;
      r.code  = {1'b0, kind};
      r.value = {8'd0, freq};
      r.phase = ph;
      r.entry = entry;
      r.pin   = pin;
      r.level = lvl;
      return r;
   endfunction

   function automatic plan_row_type csr_row(input logic [2:0] index, input logic [31:0] value);
      plan_row_type r;
      r = '0;
      r.is_csr = 1'b1;
      r.code   = index;
      r.value  = value;
      return r;
   endfunction

   // called at a falling edge while the bank is idle
   task automatic write_csr(input logic [2:0] index, input logic [31:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      case (index)
         CSR_LFO_COUNT:   count_cfg = value[5:0];
         CSR_WAVE_SHAPE:  shape_cfg = value[2:0];
         CSR_RATE_SCALE:  rate_cfg = value;
         CSR_SPREAD_STEP: spread_cfg = value;
         CSR_USE_TABLE:   use_table_cfg = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic send_request(input logic [1:0] kind, input logic [23:0] freq,
                               input logic [15:0] ph, input logic [4:0] entry,
                               input logic pin, input logic [15:0] lvl);
      int gap;
      gap = 0;
      if (sender_idles && $urandom_range(0, 3) == 0)
         gap = $urandom_range(1, 13);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid   <= 1'b1;
      req_tuser    <= kind;
      req_tdata    <= {3'd0, entry, ph, freq};
      pinned       <= pin;
      pinned_level <= lvl;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // drain all pending levels, then let set-phase/offset requests retire
   task automatic settle_bank();
      req_tvalid <= 1'b0;
      while (expected_levels.size() != 0) @(negedge clock);
      repeat (QUIET_CYCLES) @(negedge clock);
   endtask

   task automatic pick_settings(input bit full_bank);
      logic [5:0]  count;
      logic [31:0] n;
      int          r;
      r = $urandom_range(0, 9);
      if (full_bank || r == 1) count = 6'(LFO_MAX_DEF);
      else if (r == 0) count = 6'd0;
      else if (r == 2) count = 6'($urandom_range(33, 63));
      else count = 6'($urandom_range(1, 8));
      write_csr(CSR_LFO_COUNT, {26'($urandom), count});
      write_csr(CSR_WAVE_SHAPE, {29'($urandom), 3'($urandom_range(0, 7))});
      r = $urandom_range(0, 5);
      write_csr(CSR_RATE_SCALE, (r == 0) ? 32'd0 : (r == 1) ? 32'hFFFF_FFFF :
                (r == 2) ? RST_RATE_SCALE : 32'($urandom));
      n = (count == 0) ? 1 : (count > LFO_MAX_DEF) ? LFO_MAX_DEF : count;
      r = $urandom_range(0, 5);
      write_csr(CSR_SPREAD_STEP, (r < 3) ? 32'((64'd1 << 32) / n) :
                (r == 3) ? 32'd0 : 32'($urandom));
      write_csr(CSR_USE_TABLE, {31'($urandom), 1'($urandom_range(0, 1))});
      if ($urandom_range(0, 3) == 0)
         write_csr(CSR_SPARE_LO + 3'($urandom_range(0, 2)), $urandom);
   endtask

   // sine table and predictor reset state
   initial begin : lut_build
      logic [63:0] x;
      logic [63:0] t;
      logic [63:0] t2;
      logic [63:0] r;
      logic [63:0] m;
      for (int k = 0; k <= 512; k++) begin
         x  = 64'(k) << 23;   // k/512 of a cycle; the top entry wraps to zero
         t  = x[30] ? (64'd1 << 30) - {34'd0, x[29:0]} : {34'd0, x[29:0]};
         t2 = (t * t) >> 30;
         r  = K9;
         r  = K7 - ((t2 * r) >> 30);
         r  = K5 - ((t2 * r) >> 30);
         r  = K3 - ((t2 * r) >> 30);
         r  = K1 - ((t2 * r) >> 30);
         m  = (((t * r) >> 30) + 64'd32768) >> 16;
         if (m > 64'd16384) m = 64'd16384;
         sine_lut[k] = x[31] ? 16'(64'd16384 - m) : 16'(64'd16384 + m);
      end
      count_cfg     = RST_LFO_COUNT;
      shape_cfg     = SHAPE_SINE;
      rate_cfg      = RST_RATE_SCALE;
      spread_cfg    = '0;
      use_table_cfg = 1'b0;
      phase_now     = '0;
      for (int k = 0; k < 32; k++) offset_mem[k] = '0;
   end

   // predictor, result checker and watchdog
   always @(posedge clock) begin : scoreboard
      lfo_level_type want;
      logic [63:0] prod;
      logic [63:0] frac;
      logic [63:0] acc;
      logic [32:0] span;
      logic [31:0] p;
      logic [31:0] lane;
      logic [5:0]  n;
      logic [15:0] lvl;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_levels.size() == 0) begin
               report_mismatch("level with none expected", rsp_tdata[20:5], 0);
            end else begin
               want = expected_levels.pop_front();
               if (rsp_tdata[4:0] != want.lfo_index)
                  report_mismatch("lfo_index", rsp_tdata[4:0], want.lfo_index);
               if (rsp_tdata[20:5] != want.level)
                  report_mismatch("level", rsp_tdata[20:5], want.level);
               if (rsp_tlast != want.last)
                  report_mismatch("last", rsp_tlast, want.last);
            end
         end
         if (req_tvalid && req_tready) begin
            case (req_tuser)
               REQ_SET_PHASE: phase_now = {req_tdata[39:24], 16'd0};
               REQ_WR_OFFSET: offset_mem[req_tdata[44:40]] = req_tdata[39:24];
               REQ_TICK: begin
                  n = (count_cfg == 0) ? 6'd1 :
                      (count_cfg > LFO_MAX_DEF) ? 6'(LFO_MAX_DEF) : count_cfg;
                  for (lane = 0; lane < n; lane++) begin
                     p = phase_now + (use_table_cfg ? {offset_mem[lane[4:0]], 16'd0}
                                                    : lane * spread_cfg);
                     case (shape_cfg)
                        SHAPE_SQUARE:  lvl = p[31] ? 16'd32768 : 16'd0;
                        SHAPE_FALLING: lvl = 16'd32768 - 16'(p >> 17);
                        SHAPE_RISING:  lvl = 16'(p >> 17);
                        SHAPE_TENT: begin
                           span = p[31] ? 33'h1_0000_0000 - {1'b0, p} : {1'b0, p};
                           lvl  = span[31:16];
                        end
                        default: begin
                           // linear interpolation between adjacent table entries
                           frac = {32'd0, p[22:0], 9'd0};
                           acc  = sine_lut[p[31:23]] * (64'h1_0000_0000 - frac)
                                + sine_lut[p[31:23] + 10'd1] * frac + 64'h8000_0000;
                           lvl  = acc[47:32];
                        end
                     endcase
                     want.lfo_index = lane[4:0];
                     want.level     = pinned ? pinned_level : lvl;
                     want.last      = (lane + 1 == n);
                     expected_levels.push_back(want);
                  end
                  // phase advance: round(freq * rate / 2^24), mod one cycle
                  prod = {{40{req_tdata[23]}}, req_tdata[23:0]} * {32'd0, rate_cfg}
                       + 64'h80_0000;
                  phase_now = phase_now + prod[55:24];
               end
               default: ;
            endcase
         end
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t watchdog: no handshake for %0d cycles, %0d levels pending",
                     $time, idle_cycles, expected_levels.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // result side: random stalls, one long hold-off on request
   initial begin : receiver
      @(negedge clock);
      forever begin
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else if (!steady_run && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(negedge clock);
         end
      end
   end

   initial begin : stimulus
      logic [1:0]  kind;
      logic [23:0] freq;
      int          sel;
      int          done;
      plan_row_type row;

      // typed levels hold for a single LFO at the reset count
      plan.push_back(req_row(REQ_TICK, 24'd0, 16'd0, 5'd0, 1'b1, 16'd16384));
      plan.push_back(req_row(REQ_SET_PHASE, 24'd0, 16'h4000, 5'd0, 1'b0, 16'd0));
      plan.push_back(req_row(REQ_TICK, 24'd0, 16'd0, 5'd0, 1'b1, 16'd32768));
      plan.push_back(req_row(REQ_SET_PHASE, 24'd0, 16'hC000, 5'd0, 1'b0, 16'd0));
      plan.push_back(req_row(REQ_TICK, 24'd0, 16'd0, 5'd0, 1'b1, 16'd0));
      plan.push_back(csr_row(CSR_WAVE_SHAPE, {29'd0, SHAPE_SQUARE}));
      plan.push_back(req_row(REQ_SET_PHASE, 24'd0, 16'h7FFF, 5'd0, 1'b0, 16'd0));
      plan.push_back(req_row(REQ_TICK, FREQ_MAX, 16'd0, 5'd0, 1'b1, 16'd0));
      plan.push_back(req_row(REQ_TICK, 24'd0, 16'd0, 5'd0, 1'b0, 16'd0));
      plan.push_back(csr_row(CSR_WAVE_SHAPE, {29'd0, SHAPE_FALLING}));
      plan.push_back(req_row(REQ_SET_PHASE, 24'd0, 16'd0, 5'd0, 1'b0, 16'd0));
      plan.push_back(req_row(REQ_TICK, FREQ_MIN, 16'd0, 5'd0, 1'b1, 16'd32768));
      plan.push_back(csr_row(CSR_WAVE_SHAPE, {29'd0, SHAPE_RISING}));
      plan.push_back(req_row(REQ_SET_PHASE, 24'd0, 16'h8000, 5'd0, 1'b0, 16'd0));
      plan.push_back(req_row(REQ_TICK, 24'd0, 16'd0, 5'd0, 1'b1, 16'd16384));
      plan.push_back(csr_row(CSR_WAVE_SHAPE, {29'd0, SHAPE_TENT}));
      plan.push_back(req_row(REQ_TICK, 24'd0, 16'd0, 5'd0, 1'b1, 16'd32768));
      plan.push_back(csr_row(CSR_WAVE_SHAPE, {29'd0, SHAPE_UNDEFINED}));
      plan.push_back(req_row(REQ_SET_PHASE, 24'd0, 16'hFFFF, 5'd0, 1'b0, 16'd0));
      plan.push_back(req_row(REQ_TICK, 24'd0, 16'd0, 5'd0, 1'b0, 16'd0));
      plan.push_back(req_row(REQ_UNDEFINED, 24'hFF_FFFF, 16'hFFFF, 5'h1F, 1'b0, 16'd0));
      plan.push_back(csr_row(CSR_LFO_COUNT, 32'd0));
      plan.push_back(req_row(REQ_TICK, 24'd1, 16'd0, 5'd0, 1'b0, 16'd0));
      plan.push_back(csr_row(CSR_LFO_COUNT, 32'd63));
      plan.push_back(csr_row(CSR_SPREAD_STEP, 32'hFFFF_FFFF));
      plan.push_back(req_row(REQ_TICK, 24'hFF_FFFF, 16'd0, 5'd0, 1'b0, 16'd0));
      plan.push_back(csr_row(CSR_RATE_SCALE, 32'hFFFF_FFFF));
      plan.push_back(req_row(REQ_TICK, FREQ_MAX, 16'd0, 5'd0, 1'b0, 16'd0));
      plan.push_back(req_row(REQ_TICK, FREQ_MIN, 16'd0, 5'd0, 1'b0, 16'd0));
      plan.push_back(csr_row(CSR_RATE_SCALE, 32'd0));
      plan.push_back(req_row(REQ_WR_OFFSET, 24'd0, 16'hFFFF, 5'd0, 1'b0, 16'd0));
      plan.push_back(req_row(REQ_WR_OFFSET, 24'd0, 16'h8000, 5'h1F, 1'b0, 16'd0));
      plan.push_back(csr_row(CSR_USE_TABLE, 32'd1));
      plan.push_back(csr_row(CSR_SPARE_LO, 32'hFFFF_FFFF));
      plan.push_back(csr_row(CSR_SPARE_HI, 32'hFFFF_FFFF));
      plan.push_back(req_row(REQ_TICK, 24'h12_3456, 16'd0, 5'd0, 1'b0, 16'd0));

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < plan.size(); i++) begin
         row = plan[i];
         if (row.is_csr) begin
            settle_bank();
            write_csr(row.code, row.value);
         end else begin
            send_request(row.code[1:0], row.value[23:0], row.phase, row.entry,
                         row.pin, row.level);
         end
      end

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         settle_bank();
         pick_settings(ph == PRESSURE_PHASE);
         // the full bank under a long hold-off backs up into the request side
         if (ph == PRESSURE_PHASE) hold_pending = 1'b1;
         sender_idles = (ph != PRESSURE_PHASE) && (ph != RANDOM_PHASES - 1);
         steady_run   = (ph == RANDOM_PHASES - 1);
         done = 0;
         while (done < ITEMS_PER_PHASE) begin
            sel  = $urandom_range(0, 99);
            freq = ($urandom_range(0, 3) == 0) ? 24'($urandom_range(0, 4095)) - 24'd2048
                                               : 24'($urandom);
            if (sel < 60) kind = REQ_TICK;
            else if (sel < 72) kind = REQ_SET_PHASE;
            else if (sel < 94) kind = REQ_WR_OFFSET;
            else kind = REQ_UNDEFINED;
            send_request(kind, freq, 16'($urandom), 5'($urandom), 1'b0, 16'd0);
            if (kind != REQ_UNDEFINED) done++;
         end
      end

      settle_bank();
      if (expected_levels.size() != 0)
         report_mismatch("levels never delivered", 0, expected_levels.size());
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
